[hw/rtl/stoc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Self-trade order check: shared types and constants
// Beat layouts, scan link record and sequencer states.
// ----------------------------------------------------------------------------
package stoc_pkg;

   // Beat layouts (fixed by the field widths of the request and response).
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 16;
   localparam int SLOT_W      = 8;
   localparam int KEY_IN_W    = 64;
   localparam int PRICE_IN_W  = 32;
   localparam int MARGIN_W    = 16;

   localparam int SLOT_LSB    = 0;
   localparam int KEY_LSB     = 8;
   localparam int PRICE_LSB   = 72;
   localparam int SIDE_BIT    = 104;

   localparam int RSP_ACC_BIT  = 0;
   localparam int RSP_SLOT_LSB = 1;

   // Request kinds carried on tuser.
   localparam logic FUNC_CHECK   = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Order sides.
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   // Record handed from one cell to the next while a check scans the table.
   typedef struct packed {
      logic              active;
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } link_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

[hw/rtl/self_trade_order_check_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Self-trade order check core
// Pre-trade guard: rejects an order that would cross a resting order of the
// same contract on the opposite side, and keeps the table of resting orders.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  req_     in         req_tvalid/tready     tdata: slot, key, price, side
//                                            tuser: func (0 check, 1 release)
//  rsp_     out        rsp_tvalid/tready     tdata: accepted, conflict_slot
//  csr_     in         csr_valid/ready       csr_wdata: price_margin
//
//  A check beat scans the table before the block is ready again: the scan
//  token walks the chain of SLOTS cells, one cell per cycle.
//  A release beat does not scan.
//  Reset (synchronous) clears all valid bits at once, the margin and the
//  sequencer; no clearing pass is needed.
//  A new request is taken while a finished response waits on rsp_; a stalled
//  response only holds the sequencer in FINISH until rsp_tready.
//  The margin register accepts a write in every cycle.
// ----------------------------------------------------------------------------
module self_trade_order_check_core #(
   parameter int SLOTS      = 256,
   parameter int PRICE_BITS = 32,
   parameter int KEY_BITS   = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   // slave side
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] order_slot, [71:8] contract_key, [103:72] order_price,
   // [104] order_side, [111:105] zero
   input  logic [stoc_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  logic                            req_tuser,
   // master side
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] accepted, [8:1] conflict_slot, [15:9] zero
   output logic [stoc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // margin register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stoc_pkg::MARGIN_W-1:0]   csr_wdata
);
   import stoc_pkg::*;

   // Wide enough to sign-extend the price field when PRICE_BITS exceeds it.
   localparam int PX = (PRICE_BITS > PRICE_IN_W) ? PRICE_BITS : PRICE_IN_W;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type             state_ff, state_in;
   logic [MARGIN_W-1:0]   margin_ff;
   logic                  func_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  side_ff;
   logic [PRICE_BITS-1:0] price_ff;    // offset binary
   logic [PRICE_BITS:0]   thr_ff, thr_in;
   logic                  start_ff;
   logic                  res_acc_ff, res_acc_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   logic                  rsp_valid_ff;
   logic                  rsp_acc_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;

   // ---------------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------------
   logic                  req_fire;
   logic [KEY_BITS-1:0]   req_key;
   logic [PX-1:0]         req_price_wide;
   logic [PRICE_BITS-1:0] req_price_bits;
   logic [PRICE_BITS-1:0] req_price_ord;
   logic [PRICE_BITS:0]   margin_wide;
   logic [PRICE_BITS:0]   thr_up;
   logic [PRICE_BITS:0]   thr_dn;

   // Sequencer controls
   logic scan_end;
   logic store_en;
   logic clear_en;
   logic rsp_load;

   link_type link [SLOTS+1];

   assign req_fire = req_tvalid && req_tready;
   assign req_key  = req_tdata[KEY_LSB +: KEY_BITS];

   assign req_price_wide = PX'($signed(req_tdata[PRICE_LSB +: PRICE_IN_W]));
   assign req_price_bits = req_price_wide[PRICE_BITS-1:0];
   // Flip the sign bit so that unsigned order equals signed order.
   assign req_price_ord  = {~req_price_bits[PRICE_BITS-1], req_price_bits[PRICE_BITS-2:0]};

   // Precompute the crossing bound once per request:
   //   buy crosses a resting sell r when r <= p + margin
   //   sell crosses a resting buy r when r >= p - margin (floor at zero)
   assign margin_wide = (PRICE_BITS+1)'(margin_ff);
   assign thr_up      = {1'b0, req_price_ord} + margin_wide;
   assign thr_dn      = {1'b0, req_price_ord} - margin_wide;

   always_comb begin
      if (req_tdata[SIDE_BIT] == SIDE_BUY) begin
         thr_in = thr_up;
      end else if (thr_dn[PRICE_BITS]) begin
         thr_in = '0;
      end else begin
         thr_in = thr_dn;
      end
   end

   // ---------------------------------------------------------------------
   // Chain of table cells; the token enters at cell 0
   // ---------------------------------------------------------------------
   always_comb begin
      link[0].active = start_ff;
      link[0].hit    = 1'b0;
      link[0].slot   = '0;
   end

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      stoc_cell #(
         .INDEX      (g),
         .KEY_BITS   (KEY_BITS),
         .PRICE_BITS (PRICE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .prev_link (link[g]),
         .next_link (link[g+1]),
         .req_key   (key_ff),
         .req_side  (side_ff),
         .req_price (price_ff),
         .req_thr   (thr_ff),
         .upd_slot  (slot_ff),
         .store_en  (store_en),
         .clear_en  (clear_en)
      );
   end

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      scan_end   = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_SCAN: begin
            // A release finishes at once; a check waits for the token.
            scan_end = func_ff || link[SLOTS].active;
         end
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Store an order that found no conflict; drop a released slot.
   assign store_en = scan_end && (func_ff == FUNC_CHECK) && !link[SLOTS].hit;
   assign clear_en = scan_end && (func_ff == FUNC_RELEASE);

   assign res_acc_in  = (func_ff == FUNC_RELEASE) || !link[SLOTS].hit;
   assign res_slot_in = (func_ff == FUNC_RELEASE) ? '0 : link[SLOTS].slot;

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         margin_ff    <= '0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= req_fire && (req_tuser == FUNC_CHECK);
         if (csr_valid && csr_ready) begin
            margin_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff  <= req_tuser;
         slot_ff  <= req_tdata[SLOT_LSB +: SLOT_W];
         key_ff   <= req_key;
         side_ff  <= req_tdata[SIDE_BIT];
         price_ff <= req_price_ord;
         thr_ff   <= thr_in;
      end
      if (scan_end) begin
         res_acc_ff  <= res_acc_in;
         res_slot_ff <= res_slot_in;
      end
      if (rsp_load) begin
         rsp_acc_ff  <= res_acc_ff;
         rsp_slot_ff <= res_slot_ff;
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-SLOT_W-1)'(0), rsp_slot_ff, rsp_acc_ff};

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_token_in_scan: assert property (@(posedge clock) disable iff (reset)
      link[SLOTS].active |-> ((state_ff == ST_SCAN) && (func_ff == FUNC_CHECK)))
      else $error("scan token left the chain outside a check");

   a_release_quick: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SCAN) && (func_ff == FUNC_RELEASE)) |=> (state_ff == ST_FINISH))
      else $error("release did not finish in one cycle");

   a_no_store_on_hit: assert property (@(posedge clock) disable iff (reset)
      (scan_end && !res_acc_in) |-> !store_en)
      else $error("rejected order written to the table");

endmodule

[hw/rtl/stoc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Self-trade order check: table cell
// Holds one resting order and tests it against the request as the scan
// token passes.
// ----------------------------------------------------------------------------
module stoc_cell #(
   parameter int INDEX      = 0,
   parameter int KEY_BITS   = 64,
   parameter int PRICE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  stoc_pkg::link_type          prev_link,
   output stoc_pkg::link_type          next_link,
   input  logic [KEY_BITS-1:0]         req_key,
   input  logic                        req_side,
   input  logic [PRICE_BITS-1:0]       req_price,
   input  logic [PRICE_BITS:0]         req_thr,
   input  logic [stoc_pkg::SLOT_W-1:0] upd_slot,
   input  logic                        store_en,
   input  logic                        clear_en
);
   import stoc_pkg::*;

   logic                  valid_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic                  side_ff;
   logic [PRICE_BITS-1:0] price_ff;
   link_type              link_ff;
   link_type              link_in;

   logic sel;
   logic crossed;
   logic match;

   // Cells past the 8-bit slot range are never addressed.
   assign sel = (INDEX < (1 << SLOT_W)) && (upd_slot == SLOT_W'(INDEX));

   always_comb begin
      if (req_side == SIDE_BUY) begin
         crossed = {1'b0, price_ff} <= req_thr;
      end else begin
         crossed = {1'b0, price_ff} >= req_thr;
      end
   end

   assign match = prev_link.active && !prev_link.hit && valid_ff &&
                  (key_ff == req_key) && (side_ff != req_side) && crossed;

   always_comb begin
      link_in        = prev_link;
      link_in.hit    = prev_link.hit | match;
      link_in.slot   = match ? SLOT_W'(INDEX) : prev_link.slot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (sel && store_en) begin
         valid_ff <= 1'b1;
      end else if (sel && clear_en) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      link_ff.hit  <= link_in.hit;
      link_ff.slot <= link_in.slot;
      if (reset) begin
         link_ff.active <= 1'b0;
      end else begin
         link_ff.active <= link_in.active;
      end
      if (sel && store_en) begin
         key_ff   <= req_key;
         side_ff  <= req_side;
         price_ff <= req_price;
      end
   end

   assign next_link = link_ff;

endmodule
